FILE: rtl/core/gmb_pkg.sv
// ----------------------------------------------------------------------------
// gmb_pkg
// Shared types, constants and helpers for the 2x2 window mean/max search.
// ----------------------------------------------------------------------------
package gmb_pkg;

    localparam int MAX_DIM  = 64;
    localparam int DIM_W    = 7;
    localparam int POS_W    = 6;
    localparam int DEPTH_W  = 16;
    localparam int SUM_W    = 18;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = 2;
    localparam int Q_CNT_W  = 3;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [DIM_W-1:0] DIM_MIN   = 7'd2;
    localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd6;

    // register index codes
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [DEPTH_W-1:0] above;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic               win;
        logic               row_end;
        logic               frame_end;
    } t_item;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (v > DIM_MAX) begin
            r = DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/gmb_front.sv
// ----------------------------------------------------------------------------
// gmb_front
// Accepts samples, tracks raster position, reads/writes the line buffer.
// ----------------------------------------------------------------------------
module gmb_front
    import gmb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [DIM_W-1:0]   i_rows,
    input  logic [DIM_W-1:0]   i_cols,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [DEPTH_W-1:0] i_depth,
    output logic               o_push,
    output t_item              o_item,
    input  logic               i_full
);

    logic [DEPTH_W-1:0] r_line [MAX_DIM];
    logic [DEPTH_W-1:0] r_above;
    logic [POS_W-1:0]   r_col;
    logic [POS_W-1:0]   r_row;
    logic               r_fv;
    logic [DEPTH_W-1:0] r_depth;
    logic [POS_W-1:0]   r_s_row;
    logic [POS_W-1:0]   r_s_col;
    logic               r_win;
    logic               r_row_end;
    logic               r_frame_end;

    logic               w_accept;
    logic               w_row_end;
    logic               w_frame_end;
    logic [DIM_W-1:0]   w_col_p1;
    logic [DIM_W-1:0]   w_row_p1;

    assign o_push     = r_fv && !i_full;
    assign o_in_stall = r_fv && i_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_col_p1    = {1'b0, r_col} + DIM_W'(1);
    assign w_row_p1    = {1'b0, r_row} + DIM_W'(1);
    assign w_row_end   = (w_col_p1 >= i_cols);
    assign w_frame_end = w_row_end && (w_row_p1 >= i_rows);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_fv  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fv <= 1'b1;
                if (w_row_end) begin
                    r_col <= '0;
                    r_row <= w_frame_end ? '0 : w_row_p1[POS_W-1:0];
                end else begin
                    r_col <= w_col_p1[POS_W-1:0];
                end
            end else if (o_push) begin
                r_fv <= 1'b0;
            end
        end
    end

    // line buffer: read returns last row's sample, then overwritten
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_above      <= r_line[r_col];
            r_line[r_col] <= i_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_depth     <= i_depth;
            r_s_row     <= r_row;
            r_s_col     <= r_col;
            r_win       <= (r_row != '0) && (r_col != '0);
            r_row_end   <= w_row_end;
            r_frame_end <= w_frame_end;
        end
    end

    always_comb begin
        o_item.depth     = r_depth;
        o_item.above     = r_above;
        o_item.row       = r_s_row;
        o_item.col       = r_s_col;
        o_item.win       = r_win;
        o_item.row_end   = r_row_end;
        o_item.frame_end = r_frame_end;
    end

endmodule

FILE: rtl/core/gmb_queue.sv
// ----------------------------------------------------------------------------
// gmb_queue
// Short FIFO between the front and back stages.
// ----------------------------------------------------------------------------
module gmb_queue
    import gmb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: rtl/core/gmb_back.sv
// ----------------------------------------------------------------------------
// gmb_back
// Forms each 2x2 window sum and tracks the frame maximum and best window.
// ----------------------------------------------------------------------------
module gmb_back
    import gmb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [DEPTH_W-1:0] o_deepest_sample,
    output logic [SUM_W-1:0]   o_best_window_sum,
    output logic [POS_W-1:0]   o_best_row,
    output logic [POS_W-1:0]   o_best_col,
    output logic               o_window_found
);

    logic [DEPTH_W-1:0] r_left;
    logic [DEPTH_W-1:0] r_above_left;
    logic [DEPTH_W-1:0] r_max;
    logic [SUM_W-1:0]   r_sum;
    logic [POS_W-1:0]   r_brow;
    logic [POS_W-1:0]   r_bcol;
    logic               r_found;

    logic               r_ov;
    logic [DEPTH_W-1:0] r_o_deep;
    logic [SUM_W-1:0]   r_o_sum;
    logic [POS_W-1:0]   r_o_row;
    logic [POS_W-1:0]   r_o_col;
    logic               r_o_found;

    logic               w_slot;
    logic [SUM_W-1:0]   w_sum;
    logic               w_better;
    logic [DEPTH_W-1:0] n_max;
    logic [SUM_W-1:0]   n_sum;
    logic [POS_W-1:0]   n_brow;
    logic [POS_W-1:0]   n_bcol;
    logic               n_found;

    assign w_slot = !r_ov || !i_out_stall;
    assign o_pop  = i_valid && (!i_item.frame_end || w_slot);

    assign w_sum = SUM_W'(r_above_left) + SUM_W'(i_item.above)
                 + SUM_W'(r_left) + SUM_W'(i_item.depth);
    // strict compare keeps the first window in raster order on ties
    assign w_better = i_item.win && (w_sum > r_sum);

    always_comb begin
        n_max   = (i_item.depth > r_max) ? i_item.depth : r_max;
        n_sum   = r_sum;
        n_brow  = r_brow;
        n_bcol  = r_bcol;
        n_found = r_found;
        if (w_better) begin
            n_sum   = w_sum;
            n_brow  = i_item.row - POS_W'(1);
            n_bcol  = i_item.col - POS_W'(1);
            n_found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_above_left <= '0;
            r_max        <= '0;
            r_sum        <= '0;
            r_brow       <= '0;
            r_bcol       <= '0;
            r_found      <= 1'b0;
        end else if (o_pop) begin
            if (i_item.row_end) begin
                r_left       <= '0;
                r_above_left <= '0;
            end else begin
                r_left       <= i_item.depth;
                r_above_left <= i_item.above;
            end
            if (i_item.frame_end) begin
                r_max   <= '0;
                r_sum   <= '0;
                r_brow  <= '0;
                r_bcol  <= '0;
                r_found <= 1'b0;
            end else begin
                r_max   <= n_max;
                r_sum   <= n_sum;
                r_brow  <= n_brow;
                r_bcol  <= n_bcol;
                r_found <= n_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_pop && i_item.frame_end) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.frame_end) begin
            r_o_deep  <= n_max;
            r_o_sum   <= n_found ? n_sum : '0;
            r_o_row   <= n_found ? n_brow : '0;
            r_o_col   <= n_found ? n_bcol : '0;
            r_o_found <= n_found;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_deepest_sample  = r_o_deep;
    assign o_best_window_sum = r_o_sum;
    assign o_best_row        = r_o_row;
    assign o_best_col        = r_o_col;
    assign o_window_found    = r_o_found;

endmodule

FILE: rtl/core/grid_max_and_best_2x2_mean.sv
// ----------------------------------------------------------------------------
// grid_max_and_best_2x2_mean
// Raster grid of depth samples in, per-frame deepest sample and best 2x2 window out.
// ----------------------------------------------------------------------------
// throughput: one sample per cycle while o_in_stall is low, set by the single line-buffer port
// result path: after the last sample is accepted, the frame result word is registered
// through the front stage, the queue and the back tracker/output register
// reset: synchronous, active low; grid size registers return to 6x6, position
// counters and trackers clear; the line buffer is not cleared
module grid_max_and_best_2x2_mean
    import gmb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [DEPTH_W-1:0] i_depth,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [DEPTH_W-1:0] o_deepest_sample,
    output logic [SUM_W-1:0]   o_best_window_sum,
    output logic [POS_W-1:0]   o_best_row,
    output logic [POS_W-1:0]   o_best_col,
    output logic               o_window_found
);

    logic [DIM_W-1:0] r_grid_rows;
    logic [DIM_W-1:0] r_grid_cols;
    logic             w_wr;
    logic             w_idx;
    logic [DIM_W-1:0] w_rows;
    logic [DIM_W-1:0] w_cols;

    logic             w_push;
    t_item            w_push_item;
    logic             w_full;
    logic             w_q_valid;
    t_item            w_head;
    logic             w_pop;

    assign pready = 1'b1;
    assign w_idx  = paddr[2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= DIM_RESET;
            r_grid_cols <= DIM_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GRID_ROWS: r_grid_rows <= pwdata[DIM_W-1:0];
                REG_GRID_COLS: r_grid_cols <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_GRID_ROWS: prdata = DATA_W'(r_grid_rows);
            REG_GRID_COLS: prdata = DATA_W'(r_grid_cols);
            default:       prdata = '0;
        endcase
    end

    assign w_rows = clamp_dim(r_grid_rows);
    assign w_cols = clamp_dim(r_grid_cols);

    gmb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rows     (w_rows),
        .i_cols     (w_cols),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_depth    (i_depth),
        .o_push     (w_push),
        .o_item     (w_push_item),
        .i_full     (w_full)
    );

    gmb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_head),
        .i_pop   (w_pop)
    );

    gmb_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_q_valid),
        .i_item            (w_head),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_deepest_sample  (o_deepest_sample),
        .o_best_window_sum (o_best_window_sum),
        .o_best_row        (o_best_row),
        .o_best_col        (o_best_col),
        .o_window_found    (o_window_found)
    );

    // a result word only ever follows a frame-end word leaving the queue
    a_result_from_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_pop && w_head.frame_end))
        else $error("result word without frame end");

    // no window found means the window fields are all zero
    a_empty_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_window_found) |->
            (o_best_window_sum == '0 && o_best_row == '0 && o_best_col == '0))
        else $error("window fields set with no window found");

    // input side only backs up when the queue is full
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_full)
        else $error("input stalled with queue space free");

endmodule
